/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/fmul_pkg.sv */
// ----------------------------------------------------------------------------
// fmul_pkg
// Types and constants for the binary32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
package fmul_pkg;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [9:0]  EXP_BIAS = 10'd127;

  typedef enum logic [1:0] {
    SPC_NONE = 2'd0,
    SPC_NAN  = 2'd1,
    SPC_INF  = 2'd2,
    SPC_ZERO = 2'd3
  } spc_t;

  // stage 1 -> stage 2
  typedef struct packed {
    logic        sign;
    spc_t        spc;
    logic [9:0]  exp;
    logic [23:0] ma;
    logic [23:0] mb;
  } unp_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic        sign;
    spc_t        spc;
    logic [9:0]  exp;
    logic [47:0] prod;
  } mul_t;
endpackage
`default_nettype wire

/* hdl/fmul_if.sv */
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for operands and products.
// ----------------------------------------------------------------------------
`default_nettype none
interface fmul_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, operand_a, operand_b, input ready);
  modport sink (input valid, operand_a, operand_b, output ready);
endinterface

interface fmul_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] product;
  modport source (output valid, product, input ready);
  modport sink (input valid, product, output ready);
endinterface
`default_nettype wire

/* hdl/float32_multiplier.sv */
// ----------------------------------------------------------------------------
// float32_multiplier
// Pipelined IEEE-754 binary32 multiplier with flush-to-zero.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in       sink operand_a[31:0], operand_b[31:0]
// out      src  product[31:0]
// One transfer per cycle while the pipeline advances; registered stages: unpack
// register, 24x24 multiply register, round into the output register. The 24x24
// multiply sets the stage depth.
// The pipeline advances when the output register is empty or being taken;
// a stall holds every stage. Reset clears the valid bits.
`default_nettype none
`include "assert_macros.svh"
module float32_multiplier (
  input wire logic         clk,
  input wire logic         rst,
  fmul_in_if.sink          in_ch,
  fmul_out_if.source       out_ch
);
  fmul_pkg::unp_t unp_next, unp;
  fmul_pkg::mul_t mul;
  logic [31:0]    rnd_next, res;
  logic           v1, v2, v3;
  logic           adv;

  assign adv = !v3 || out_ch.ready;
  assign in_ch.ready = adv;

  fmul_unpack u_unpack (.a(in_ch.operand_a), .b(in_ch.operand_b), .unp(unp_next));
  fmul_round u_round (.mul(mul), .product(rnd_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unp <= unp_next;
      mul.sign <= unp.sign;
      mul.spc <= unp.spc;
      mul.exp <= unp.exp;
      mul.prod <= unp.ma * unp.mb;
      res <= rnd_next;
    end
  end

  assign out_ch.valid = v3;
  assign out_ch.product = res;

  `ASSERT_NEXT(a_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `ASSERT_IMPL(a_rdy, clk, rst, !out_ch.valid, in_ch.ready)
  `ASSERT_NEXT(a_flow, clk, rst, in_ch.valid && in_ch.ready, v1)
endmodule
`default_nettype wire

/* hdl/fmul_unpack.sv */
// ----------------------------------------------------------------------------
// fmul_unpack
// Field split, special-case classification and exponent sum.
// ----------------------------------------------------------------------------
`default_nettype none
module fmul_unpack (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output fmul_pkg::unp_t   unp
);
  logic [7:0] ea, eb;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (ea == 8'd0);
    b_zero = (eb == 8'd0);
    unp.sign = a[31] ^ b[31];
    unp.exp = {2'b00, ea} + {2'b00, eb} - fmul_pkg::EXP_BIAS;
    unp.ma = {1'b1, a[22:0]};
    unp.mb = {1'b1, b[22:0]};
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      unp.spc = fmul_pkg::SPC_NAN;
    end else if (a_inf || b_inf) begin
      unp.spc = fmul_pkg::SPC_INF;
    end else if (a_zero || b_zero) begin
      unp.spc = fmul_pkg::SPC_ZERO;
    end else begin
      unp.spc = fmul_pkg::SPC_NONE;
    end
  end
endmodule
`default_nettype wire

/* hdl/fmul_round.sv */
// ----------------------------------------------------------------------------
// fmul_round
// Normalize, round to nearest even, range check and pack.
// ----------------------------------------------------------------------------
`default_nettype none
module fmul_round (
  input  wire fmul_pkg::mul_t mul,
  output logic [31:0]       product
);
  logic [23:0] mant;
  logic        guard, sticky;
  logic [24:0] rnd;
  logic [9:0]  e;

  always_comb begin
    if (mul.prod[47]) begin
      mant = mul.prod[47:24];
      guard = mul.prod[23];
      sticky = |mul.prod[22:0];
      e = mul.exp + 10'd1;
    end else begin
      mant = mul.prod[46:23];
      guard = mul.prod[22];
      sticky = |mul.prod[21:0];
      e = mul.exp;
    end
    rnd = {1'b0, mant} + {24'd0, guard & (sticky | mant[0])};
    if (rnd[24]) begin
      rnd = {1'b0, rnd[24:1]};
      e = e + 10'd1;
    end
    unique case (mul.spc)
      fmul_pkg::SPC_NAN:  product = fmul_pkg::QNAN;
      fmul_pkg::SPC_INF:  product = {mul.sign, 8'hFF, 23'd0};
      fmul_pkg::SPC_ZERO: product = {mul.sign, 31'd0};
      default: begin
        // e is signed 10-bit: negative or zero underflows
        if (e[9] || e == 10'd0) begin
          product = {mul.sign, 31'd0};
        end else if (e >= 10'd255) begin
          product = {mul.sign, 8'hFF, 23'd0};
        end else begin
          product = {mul.sign, e[7:0], rnd[22:0]};
        end
      end
    endcase
  end
endmodule
`default_nettype wire

/* test/tb_float32_multiplier.sv */
// ----------------------------------------------------------------------------
// tb_float32_multiplier
// Drives operand pairs through the binary32 multiplier and checks every
// product against a flush-to-zero, round-to-nearest-even predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_float32_multiplier;

  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] EXP_FIELD = 32'h7F80_0000;
  localparam logic [31:0] FRAC_FIELD = 32'h007F_FFFF;
  localparam logic [31:0] HIDDEN    = 32'h0080_0000;
  localparam int          N_RANDOM  = 1030;
  localparam int          STALL_LIMIT = 2000;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] want;
    bit          typed;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  fmul_in_if  in_ch();
  fmul_out_if out_ch();

  float32_multiplier dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  logic [31:0] product_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int idle_cycles = 0;
  bit sending_done = 1'b0;
  bit no_idle = 1'b0;
  bit hold_sink = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] fmul_product(logic [31:0] a, logic [31:0] b);
    logic [31:0] sign;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [47:0] prod;
    logic [24:0] mant;
    logic        guard, sticky;
    int          e;
    sign = (a ^ b) & SIGN_BIT;
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0)) return fmul_pkg::QNAN;
    if ((ea == 8'hFF && eb == 0) || (eb == 8'hFF && ea == 0)) return fmul_pkg::QNAN;
    if (ea == 8'hFF || eb == 8'hFF) return sign | EXP_FIELD;
    if (ea == 0 || eb == 0) return sign;
    prod = {24'd0, 1'b1, fa} * {24'd0, 1'b1, fb};
    e = int'(ea) + int'(eb) - int'(fmul_pkg::EXP_BIAS);
    if (prod[47]) begin
      mant = {1'b0, prod[47:24]};
      guard = prod[23];
      sticky = |prod[22:0];
      e++;
    end else begin
      mant = {1'b0, prod[46:23]};
      guard = prod[22];
      sticky = |prod[21:0];
    end
    if (guard && (sticky || mant[0])) mant++;
    if (mant[24]) begin
      mant = mant >> 1;
      e++;
    end
    if (e >= 255) return sign | EXP_FIELD;
    if (e <= 0) return sign;
    return sign | (32'(e) << 23) | (32'(mant) & FRAC_FIELD);
  endfunction

  // Random operand with biased classes: specials, small/large exponents, ones.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    int k;
    v = $urandom;
    k = $urandom_range(0, 99);
    if (k < 5) v[30:23] = 8'hFF;
    else if (k < 10) v[30:23] = 8'h00;
    else if (k < 20) v[30:23] = 8'($urandom_range(1, 8));
    else if (k < 30) v[30:23] = 8'($urandom_range(240, 254));
    else if (k < 40) v[30:23] = 8'($urandom_range(100, 150));
    if (k >= 40 && k < 45) v[22:0] = 23'h7FFFFF;
    if (k >= 45 && k < 50) v[22:0] = 23'(1 << $urandom_range(0, 22));
    return v;
  endfunction

  task automatic send_operands(logic [31:0] a, logic [31:0] b);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    product_q.push_back(fmul_product(a, b));
    n_sent++;
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (product_q.size() != 0) @(posedge clk);
  endtask

  vec_t directed[] = '{
    '{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1},
    '{32'h7FC0_0001, 32'h3F80_0000, fmul_pkg::QNAN, 1'b1},
    '{32'h3F80_0000, 32'hFF80_0001, fmul_pkg::QNAN, 1'b1},
    '{32'h7F80_0000, 32'h0000_0000, fmul_pkg::QNAN, 1'b1},
    '{32'h8000_0000, 32'hFF80_0000, fmul_pkg::QNAN, 1'b1},
    '{32'h7F80_0000, 32'h0000_0001, fmul_pkg::QNAN, 1'b1},
    '{32'h7F80_0000, 32'hBF80_0000, 32'hFF80_0000, 1'b1},
    '{32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b1},
    '{32'h0000_0000, 32'hC000_0000, 32'h8000_0000, 1'b1},
    '{32'h807F_FFFF, 32'h3F80_0000, 32'h8000_0000, 1'b1},
    '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F80_0000, 1'b1},
    '{32'h0080_0000, 32'h0080_0000, 32'h0000_0000, 1'b1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, fmul_pkg::QNAN, 1'b1},
    '{32'h3F7F_FFFF, 32'h0080_0001, 32'h0, 1'b0},
    '{32'h3F80_0001, 32'h007F_FFFF, 32'h0, 1'b0},
    '{32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h0, 1'b0},
    '{32'h3F80_0001, 32'h3F80_0001, 32'h0, 1'b0},
    '{32'h3FC0_0000, 32'h3FC0_0000, 32'h0, 1'b0},
    '{32'h7F00_0000, 32'h4000_0000, 32'h0, 1'b0},
    '{32'h3F7F_FFFF, 32'h0080_0000, 32'h0, 1'b0},
    '{32'h2000_0000, 32'h2000_0000, 32'h0, 1'b0},
    '{32'h3F80_0003, 32'h3F7F_FFFF, 32'h0, 1'b0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 1'b0}
  };

  // Sender
  initial begin
    in_ch.valid = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].typed &&
          fmul_product(directed[i].a, directed[i].b) != directed[i].want) begin
        $error("table row %0d: predictor gives %08h, table %08h", i,
               fmul_product(directed[i].a, directed[i].b), directed[i].want);
        errors++;
      end
      send_operands(directed[i].a, directed[i].b);
    end
    drain_wait();
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 300 && i < 450);
      if (i == 600) hold_sink = 1'b1;
      if (i == 800) drain_wait();
      send_operands(pick_operand(), pick_operand());
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver
  initial begin
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        n_got++;
        if (product_q.size() == 0) begin
          $error("product %08h with nothing expected", out_ch.product);
          errors++;
        end else begin
          logic [31:0] want;
          want = product_q.pop_front();
          if (out_ch.product !== want) begin
            $error("product: expected %08h, actual %08h", want, out_ch.product);
            errors++;
          end
        end
      end
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_sink = 1'b0;
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // Watchdog and end of run
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL float32_multiplier");
        $finish;
      end
      if (sending_done && product_q.size() == 0) begin
        repeat (10) @(posedge clk);
        $display("Run covered %0d operand transfers and %0d product transfers,",
                 n_sent, n_got);
        $display("including specials, rounding carries, overflow and flush to zero.");
        if (errors == 0 && product_q.size() == 0)
          $display("PASS float32_multiplier");
        else
          $display("FAIL float32_multiplier");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
